@@ rtl/core/blf_pkg.sv @@
// Shared types, codes and pi-derived initial tables of the Blowfish engine.
package blf_pkg;

   localparam int ROUNDS        = 16;
   localparam int MAX_KEY_WORDS = 14;
   localparam int P_LEN         = ROUNDS + 2;
   localparam int SBOX_NUM      = 4;
   localparam int SBOX_DEPTH    = 256;
   localparam int P_PAIRS       = P_LEN / 2;
   localparam int S_PAIRS       = SBOX_NUM * SBOX_DEPTH / 2;

   // Item functions carried on tuser
   localparam logic [1:0] FUNC_LOAD    = 2'd0;
   localparam logic [1:0] FUNC_EXPAND  = 2'd1;
   localparam logic [1:0] FUNC_ENCRYPT = 2'd2;
   localparam logic [1:0] FUNC_DECRYPT = 2'd3;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_INIT  = 6'b000010,
      ST_START = 6'b000100,
      ST_ROUND = 6'b001000,
      ST_WR2   = 6'b010000,
      ST_HOLD  = 6'b100000
   } state_type;

   // One S-box RAM write request
   typedef struct packed {
      logic        we;
      logic [7:0]  addr;
      logic [31:0] data;
   } sbox_wr_type;

   localparam logic [31:0] P_INIT [P_LEN] = '{
      32'h243F6A88, 32'h85A308D3, 32'h13198A2E, 32'h03707344, 32'hA4093822, 32'h299F31D0,
      32'h082EFA98, 32'hEC4E6C89, 32'h452821E6, 32'h38D01377, 32'hBE5466CF, 32'h34E90C6C,
      32'hC0AC29B7, 32'hC97C50DD, 32'h3F84D5B5, 32'hB5470917, 32'h9216D5D9, 32'h8979FB1B
   };

   localparam logic [31:0] S_INIT [SBOX_NUM][SBOX_DEPTH] = '{
      '{
      32'hD1310BA6, 32'h98DFB5AC, 32'h2FFD72DB, 32'hD01ADFB7, 32'hB8E1AFED, 32'h6A267E96,
      32'hBA7C9045, 32'hF12C7F99, 32'h24A19947, 32'hB3916CF7, 32'h0801F2E2, 32'h858EFC16,
      32'h636920D8, 32'h71574E69, 32'hA458FEA3, 32'hF4933D7E, 32'h0D95748F, 32'h728EB658,
      32'h718BCD58, 32'h82154AEE, 32'h7B54A41D, 32'hC25A59B5, 32'h9C30D539, 32'h2AF26013,
      32'hC5D1B023, 32'h286085F0, 32'hCA417918, 32'hB8DB38EF, 32'h8E79DCB0, 32'h603A180E,
      32'h6C9E0E8B, 32'hB01E8A3E, 32'hD71577C1, 32'hBD314B27, 32'h78AF2FDA, 32'h55605C60,
      32'hE65525F3, 32'hAA55AB94, 32'h57489862, 32'h63E81440, 32'h55CA396A, 32'h2AAB10B6,
      32'hB4CC5C34, 32'h1141E8CE, 32'hA15486AF, 32'h7C72E993, 32'hB3EE1411, 32'h636FBC2A,
      32'h2BA9C55D, 32'h741831F6, 32'hCE5C3E16, 32'h9B87931E, 32'hAFD6BA33, 32'h6C24CF5C,
      32'h7A325381, 32'h28958677, 32'h3B8F4898, 32'h6B4BB9AF, 32'hC4BFE81B, 32'h66282193,
      32'h61D809CC, 32'hFB21A991, 32'h487CAC60, 32'h5DEC8032, 32'hEF845D5D, 32'hE98575B1,
      32'hDC262302, 32'hEB651B88, 32'h23893E81, 32'hD396ACC5, 32'h0F6D6FF3, 32'h83F44239,
      32'h2E0B4482, 32'hA4842004, 32'h69C8F04A, 32'h9E1F9B5E, 32'h21C66842, 32'hF6E96C9A,
      32'h670C9C61, 32'hABD388F0, 32'h6A51A0D2, 32'hD8542F68, 32'h960FA728, 32'hAB5133A3,
      32'h6EEF0B6C, 32'h137A3BE4, 32'hBA3BF050, 32'h7EFB2A98, 32'hA1F1651D, 32'h39AF0176,
      32'h66CA593E, 32'h82430E88, 32'h8CEE8619, 32'h456F9FB4, 32'h7D84A5C3, 32'h3B8B5EBE,
      32'hE06F75D8, 32'h85C12073, 32'h401A449F, 32'h56C16AA6, 32'h4ED3AA62, 32'h363F7706,
      32'h1BFEDF72, 32'h429B023D, 32'h37D0D724, 32'hD00A1248, 32'hDB0FEAD3, 32'h49F1C09B,
      32'h075372C9, 32'h80991B7B, 32'h25D479D8, 32'hF6E8DEF7, 32'hE3FE501A, 32'hB6794C3B,
      32'h976CE0BD, 32'h04C006BA, 32'hC1A94FB6, 32'h409F60C4, 32'h5E5C9EC2, 32'h196A2463,
      32'h68FB6FAF, 32'h3E6C53B5, 32'h1339B2EB, 32'h3B52EC6F, 32'h6DFC511F, 32'h9B30952C,
      32'hCC814544, 32'hAF5EBD09, 32'hBEE3D004, 32'hDE334AFD, 32'h660F2807, 32'h192E4BB3,
      32'hC0CBA857, 32'h45C8740F, 32'hD20B5F39, 32'hB9D3FBDB, 32'h5579C0BD, 32'h1A60320A,
      32'hD6A100C6, 32'h402C7279, 32'h679F25FE, 32'hFB1FA3CC, 32'h8EA5E9F8, 32'hDB3222F8,
      32'h3C7516DF, 32'hFD616B15, 32'h2F501EC8, 32'hAD0552AB, 32'h323DB5FA, 32'hFD238760,
      32'h53317B48, 32'h3E00DF82, 32'h9E5C57BB, 32'hCA6F8CA0, 32'h1A87562E, 32'hDF1769DB,
      32'hD542A8F6, 32'h287EFFC3, 32'hAC6732C6, 32'h8C4F5573, 32'h695B27B0, 32'hBBCA58C8,
      32'hE1FFA35D, 32'hB8F011A0, 32'h10FA3D98, 32'hFD2183B8, 32'h4AFCB56C, 32'h2DD1D35B,
      32'h9A53E479, 32'hB6F84565, 32'hD28E49BC, 32'h4BFB9790, 32'hE1DDF2DA, 32'hA4CB7E33,
      32'h62FB1341, 32'hCEE4C6E8, 32'hEF20CADA, 32'h36774C01, 32'hD07E9EFE, 32'h2BF11FB4,
      32'h95DBDA4D, 32'hAE909198, 32'hEAAD8E71, 32'h6B93D5A0, 32'hD08ED1D0, 32'hAFC725E0,
      32'h8E3C5B2F, 32'h8E7594B7, 32'h8FF6E2FB, 32'hF2122B64, 32'h8888B812, 32'h900DF01C,
      32'h4FAD5EA0, 32'h688FC31C, 32'hD1CFF191, 32'hB3A8C1AD, 32'h2F2F2218, 32'hBE0E1777,
      32'hEA752DFE, 32'h8B021FA1, 32'hE5A0CC0F, 32'hB56F74E8, 32'h18ACF3D6, 32'hCE89E299,
      32'hB4A84FE0, 32'hFD13E0B7, 32'h7CC43B81, 32'hD2ADA8D9, 32'h165FA266, 32'h80957705,
      32'h93CC7314, 32'h211A1477, 32'hE6AD2065, 32'h77B5FA86, 32'hC75442F5, 32'hFB9D35CF,
      32'hEBCDAF0C, 32'h7B3E89A0, 32'hD6411BD3, 32'hAE1E7E49, 32'h00250E2D, 32'h2071B35E,
      32'h226800BB, 32'h57B8E0AF, 32'h2464369B, 32'hF009B91E, 32'h5563911D, 32'h59DFA6AA,
      32'h78C14389, 32'hD95A537F, 32'h207D5BA2, 32'h02E5B9C5, 32'h83260376, 32'h6295CFA9,
      32'h11C81968, 32'h4E734A41, 32'hB3472DCA, 32'h7B14A94A, 32'h1B510052, 32'h9A532915,
      32'hD60F573F, 32'hBC9BC6E4, 32'h2B60A476, 32'h81E67400, 32'h08BA6FB5, 32'h571BE91F,
      32'hF296EC6B, 32'h2A0DD915, 32'hB6636521, 32'hE7B9F9B6, 32'hFF34052E, 32'hC5855664,
      32'h53B02D5D, 32'hA99F8FA1, 32'h08BA4799, 32'h6E85076A
      },
      '{
      32'h4B7A70E9, 32'hB5B32944, 32'hDB75092E, 32'hC4192623, 32'hAD6EA6B0, 32'h49A7DF7D,
      32'h9CEE60B8, 32'h8FEDB266, 32'hECAA8C71, 32'h699A17FF, 32'h5664526C, 32'hC2B19EE1,
      32'h193602A5, 32'h75094C29, 32'hA0591340, 32'hE4183A3E, 32'h3F54989A, 32'h5B429D65,
      32'h6B8FE4D6, 32'h99F73FD6, 32'hA1D29C07, 32'hEFE830F5, 32'h4D2D38E6, 32'hF0255DC1,
      32'h4CDD2086, 32'h8470EB26, 32'h6382E9C6, 32'h021ECC5E, 32'h09686B3F, 32'h3EBAEFC9,
      32'h3C971814, 32'h6B6A70A1, 32'h687F3584, 32'h52A0E286, 32'hB79C5305, 32'hAA500737,
      32'h3E07841C, 32'h7FDEAE5C, 32'h8E7D44EC, 32'h5716F2B8, 32'hB03ADA37, 32'hF0500C0D,
      32'hF01C1F04, 32'h0200B3FF, 32'hAE0CF51A, 32'h3CB574B2, 32'h25837A58, 32'hDC0921BD,
      32'hD19113F9, 32'h7CA92FF6, 32'h94324773, 32'h22F54701, 32'h3AE5E581, 32'h37C2DADC,
      32'hC8B57634, 32'h9AF3DDA7, 32'hA9446146, 32'h0FD0030E, 32'hECC8C73E, 32'hA4751E41,
      32'hE238CD99, 32'h3BEA0E2F, 32'h3280BBA1, 32'h183EB331, 32'h4E548B38, 32'h4F6DB908,
      32'h6F420D03, 32'hF60A04BF, 32'h2CB81290, 32'h24977C79, 32'h5679B072, 32'hBCAF89AF,
      32'hDE9A771F, 32'hD9930810, 32'hB38BAE12, 32'hDCCF3F2E, 32'h5512721F, 32'h2E6B7124,
      32'h501ADDE6, 32'h9F84CD87, 32'h7A584718, 32'h7408DA17, 32'hBC9F9ABC, 32'hE94B7D8C,
      32'hEC7AEC3A, 32'hDB851DFA, 32'h63094366, 32'hC464C3D2, 32'hEF1C1847, 32'h3215D908,
      32'hDD433B37, 32'h24C2BA16, 32'h12A14D43, 32'h2A65C451, 32'h50940002, 32'h133AE4DD,
      32'h71DFF89E, 32'h10314E55, 32'h81AC77D6, 32'h5F11199B, 32'h043556F1, 32'hD7A3C76B,
      32'h3C11183B, 32'h5924A509, 32'hF28FE6ED, 32'h97F1FBFA, 32'h9EBABF2C, 32'h1E153C6E,
      32'h86E34570, 32'hEAE96FB1, 32'h860E5E0A, 32'h5A3E2AB3, 32'h771FE71C, 32'h4E3D06FA,
      32'h2965DCB9, 32'h99E71D0F, 32'h803E89D6, 32'h5266C825, 32'h2E4CC978, 32'h9C10B36A,
      32'hC6150EBA, 32'h94E2EA78, 32'hA5FC3C53, 32'h1E0A2DF4, 32'hF2F74EA7, 32'h361D2B3D,
      32'h1939260F, 32'h19C27960, 32'h5223A708, 32'hF71312B6, 32'hEBADFE6E, 32'hEAC31F66,
      32'hE3BC4595, 32'hA67BC883, 32'hB17F37D1, 32'h018CFF28, 32'hC332DDEF, 32'hBE6C5AA5,
      32'h65582185, 32'h68AB9802, 32'hEECEA50F, 32'hDB2F953B, 32'h2AEF7DAD, 32'h5B6E2F84,
      32'h1521B628, 32'h29076170, 32'hECDD4775, 32'h619F1510, 32'h13CCA830, 32'hEB61BD96,
      32'h0334FE1E, 32'hAA0363CF, 32'hB5735C90, 32'h4C70A239, 32'hD59E9E0B, 32'hCBAADE14,
      32'hEECC86BC, 32'h60622CA7, 32'h9CAB5CAB, 32'hB2F3846E, 32'h648B1EAF, 32'h19BDF0CA,
      32'hA02369B9, 32'h655ABB50, 32'h40685A32, 32'h3C2AB4B3, 32'h319EE9D5, 32'hC021B8F7,
      32'h9B540B19, 32'h875FA099, 32'h95F7997E, 32'h623D7DA8, 32'hF837889A, 32'h97E32D77,
      32'h11ED935F, 32'h16681281, 32'h0E358829, 32'hC7E61FD6, 32'h96DEDFA1, 32'h7858BA99,
      32'h57F584A5, 32'h1B227263, 32'h9B83C3FF, 32'h1AC24696, 32'hCDB30AEB, 32'h532E3054,
      32'h8FD948E4, 32'h6DBC3128, 32'h58EBF2EF, 32'h34C6FFEA, 32'hFE28ED61, 32'hEE7C3C73,
      32'h5D4A14D9, 32'hE864B7E3, 32'h42105D14, 32'h203E13E0, 32'h45EEE2B6, 32'hA3AAABEA,
      32'hDB6C4F15, 32'hFACB4FD0, 32'hC742F442, 32'hEF6ABBB5, 32'h654F3B1D, 32'h41CD2105,
      32'hD81E799E, 32'h86854DC7, 32'hE44B476A, 32'h3D816250, 32'hCF62A1F2, 32'h5B8D2646,
      32'hFC8883A0, 32'hC1C7B6A3, 32'h7F1524C3, 32'h69CB7492, 32'h47848A0B, 32'h5692B285,
      32'h095BBF00, 32'hAD19489D, 32'h1462B174, 32'h23820E00, 32'h58428D2A, 32'h0C55F5EA,
      32'h1DADF43E, 32'h233F7061, 32'h3372F092, 32'h8D937E41, 32'hD65FECF1, 32'h6C223BDB,
      32'h7CDE3759, 32'hCBEE7460, 32'h4085F2A7, 32'hCE77326E, 32'hA6078084, 32'h19F8509E,
      32'hE8EFD855, 32'h61D99735, 32'hA969A7AA, 32'hC50C06C2, 32'h5A04ABFC, 32'h800BCADC,
      32'h9E447A2E, 32'hC3453484, 32'hFDD56705, 32'h0E1E9EC9, 32'hDB73DBD3, 32'h105588CD,
      32'h675FDA79, 32'hE3674340, 32'hC5C43465, 32'h713E38D8, 32'h3D28F89E, 32'hF16DFF20,
      32'h153E21E7, 32'h8FB03D4A, 32'hE6E39F2B, 32'hDB83ADF7
      },
      '{
      32'hE93D5A68, 32'h948140F7, 32'hF64C261C, 32'h94692934, 32'h411520F7, 32'h7602D4F7,
      32'hBCF46B2E, 32'hD4A20068, 32'hD4082471, 32'h3320F46A, 32'h43B7D4B7, 32'h500061AF,
      32'h1E39F62E, 32'h97244546, 32'h14214F74, 32'hBF8B8840, 32'h4D95FC1D, 32'h96B591AF,
      32'h70F4DDD3, 32'h66A02F45, 32'hBFBC09EC, 32'h03BD9785, 32'h7FAC6DD0, 32'h31CB8504,
      32'h96EB27B3, 32'h55FD3941, 32'hDA2547E6, 32'hABCA0A9A, 32'h28507825, 32'h530429F4,
      32'h0A2C86DA, 32'hE9B66DFB, 32'h68DC1462, 32'hD7486900, 32'h680EC0A4, 32'h27A18DEE,
      32'h4F3FFEA2, 32'hE887AD8C, 32'hB58CE006, 32'h7AF4D6B6, 32'hAACE1E7C, 32'hD3375FEC,
      32'hCE78A399, 32'h406B2A42, 32'h20FE9E35, 32'hD9F385B9, 32'hEE39D7AB, 32'h3B124E8B,
      32'h1DC9FAF7, 32'h4B6D1856, 32'h26A36631, 32'hEAE397B2, 32'h3A6EFA74, 32'hDD5B4332,
      32'h6841E7F7, 32'hCA7820FB, 32'hFB0AF54E, 32'hD8FEB397, 32'h454056AC, 32'hBA489527,
      32'h55533A3A, 32'h20838D87, 32'hFE6BA9B7, 32'hD096954B, 32'h55A867BC, 32'hA1159A58,
      32'hCCA92963, 32'h99E1DB33, 32'hA62A4A56, 32'h3F3125F9, 32'h5EF47E1C, 32'h9029317C,
      32'hFDF8E802, 32'h04272F70, 32'h80BB155C, 32'h05282CE3, 32'h95C11548, 32'hE4C66D22,
      32'h48C1133F, 32'hC70F86DC, 32'h07F9C9EE, 32'h41041F0F, 32'h404779A4, 32'h5D886E17,
      32'h325F51EB, 32'hD59BC0D1, 32'hF2BCC18F, 32'h41113564, 32'h257B7834, 32'h602A9C60,
      32'hDFF8E8A3, 32'h1F636C1B, 32'h0E12B4C2, 32'h02E1329E, 32'hAF664FD1, 32'hCAD18115,
      32'h6B2395E0, 32'h333E92E1, 32'h3B240B62, 32'hEEBEB922, 32'h85B2A20E, 32'hE6BA0D99,
      32'hDE720C8C, 32'h2DA2F728, 32'hD0127845, 32'h95B794FD, 32'h647D0862, 32'hE7CCF5F0,
      32'h5449A36F, 32'h877D48FA, 32'hC39DFD27, 32'hF33E8D1E, 32'h0A476341, 32'h992EFF74,
      32'h3A6F6EAB, 32'hF4F8FD37, 32'hA812DC60, 32'hA1EBDDF8, 32'h991BE14C, 32'hDB6E6B0D,
      32'hC67B5510, 32'h6D672C37, 32'h2765D43B, 32'hDCD0E804, 32'hF1290DC7, 32'hCC00FFA3,
      32'hB5390F92, 32'h690FED0B, 32'h667B9FFB, 32'hCEDB7D9C, 32'hA091CF0B, 32'hD9155EA3,
      32'hBB132F88, 32'h515BAD24, 32'h7B9479BF, 32'h763BD6EB, 32'h37392EB3, 32'hCC115979,
      32'h8026E297, 32'hF42E312D, 32'h6842ADA7, 32'hC66A2B3B, 32'h12754CCC, 32'h782EF11C,
      32'h6A124237, 32'hB79251E7, 32'h06A1BBE6, 32'h4BFB6350, 32'h1A6B1018, 32'h11CAEDFA,
      32'h3D25BDD8, 32'hE2E1C3C9, 32'h44421659, 32'h0A121386, 32'hD90CEC6E, 32'hD5ABEA2A,
      32'h64AF674E, 32'hDA86A85F, 32'hBEBFE988, 32'h64E4C3FE, 32'h9DBC8057, 32'hF0F7C086,
      32'h60787BF8, 32'h6003604D, 32'hD1FD8346, 32'hF6381FB0, 32'h7745AE04, 32'hD736FCCC,
      32'h83426B33, 32'hF01EAB71, 32'hB0804187, 32'h3C005E5F, 32'h77A057BE, 32'hBDE8AE24,
      32'h55464299, 32'hBF582E61, 32'h4E58F48F, 32'hF2DDFDA2, 32'hF474EF38, 32'h8789BDC2,
      32'h5366F9C3, 32'hC8B38E74, 32'hB475F255, 32'h46FCD9B9, 32'h7AEB2661, 32'h8B1DDF84,
      32'h846A0E79, 32'h915F95E2, 32'h466E598E, 32'h20B45770, 32'h8CD55591, 32'hC902DE4C,
      32'hB90BACE1, 32'hBB8205D0, 32'h11A86248, 32'h7574A99E, 32'hB77F19B6, 32'hE0A9DC09,
      32'h662D09A1, 32'hC4324633, 32'hE85A1F02, 32'h09F0BE8C, 32'h4A99A025, 32'h1D6EFE10,
      32'h1AB93D1D, 32'h0BA5A4DF, 32'hA186F20F, 32'h2868F169, 32'hDCB7DA83, 32'h573906FE,
      32'hA1E2CE9B, 32'h4FCD7F52, 32'h50115E01, 32'hA70683FA, 32'hA002B5C4, 32'h0DE6D027,
      32'h9AF88C27, 32'h773F8641, 32'hC3604C06, 32'h61A806B5, 32'hF0177A28, 32'hC0F586E0,
      32'h006058AA, 32'h30DC7D62, 32'h11E69ED7, 32'h2338EA63, 32'h53C2DD94, 32'hC2C21634,
      32'hBBCBEE56, 32'h90BCB6DE, 32'hEBFC7DA1, 32'hCE591D76, 32'h6F05E409, 32'h4B7C0188,
      32'h39720A3D, 32'h7C927C24, 32'h86E3725F, 32'h724D9DB9, 32'h1AC15BB4, 32'hD39EB8FC,
      32'hED545578, 32'h08FCA5B5, 32'hD83D7CD3, 32'h4DAD0FC4, 32'h1E50EF5E, 32'hB161E6F8,
      32'hA28514D9, 32'h6C51133C, 32'h6FD5C7E7, 32'h56E14EC4, 32'h362ABFCE, 32'hDDC6C837,
      32'hD79A3234, 32'h92638212, 32'h670EFA8E, 32'h406000E0
      },
      '{
      32'h3A39CE37, 32'hD3FAF5CF, 32'hABC27737, 32'h5AC52D1B, 32'h5CB0679E, 32'h4FA33742,
      32'hD3822740, 32'h99BC9BBE, 32'hD5118E9D, 32'hBF0F7315, 32'hD62D1C7E, 32'hC700C47B,
      32'hB78C1B6B, 32'h21A19045, 32'hB26EB1BE, 32'h6A366EB4, 32'h5748AB2F, 32'hBC946E79,
      32'hC6A376D2, 32'h6549C2C8, 32'h530FF8EE, 32'h468DDE7D, 32'hD5730A1D, 32'h4CD04DC6,
      32'h2939BBDB, 32'hA9BA4650, 32'hAC9526E8, 32'hBE5EE304, 32'hA1FAD5F0, 32'h6A2D519A,
      32'h63EF8CE2, 32'h9A86EE22, 32'hC089C2B8, 32'h43242EF6, 32'hA51E03AA, 32'h9CF2D0A4,
      32'h83C061BA, 32'h9BE96A4D, 32'h8FE51550, 32'hBA645BD6, 32'h2826A2F9, 32'hA73A3AE1,
      32'h4BA99586, 32'hEF5562E9, 32'hC72FEFD3, 32'hF752F7DA, 32'h3F046F69, 32'h77FA0A59,
      32'h80E4A915, 32'h87B08601, 32'h9B09E6AD, 32'h3B3EE593, 32'hE990FD5A, 32'h9E34D797,
      32'h2CF0B7D9, 32'h022B8B51, 32'h96D5AC3A, 32'h017DA67D, 32'hD1CF3ED6, 32'h7C7D2D28,
      32'h1F9F25CF, 32'hADF2B89B, 32'h5AD6B472, 32'h5A88F54C, 32'hE029AC71, 32'hE019A5E6,
      32'h47B0ACFD, 32'hED93FA9B, 32'hE8D3C48D, 32'h283B57CC, 32'hF8D56629, 32'h79132E28,
      32'h785F0191, 32'hED756055, 32'hF7960E44, 32'hE3D35E8C, 32'h15056DD4, 32'h88F46DBA,
      32'h03A16125, 32'h0564F0BD, 32'hC3EB9E15, 32'h3C9057A2, 32'h97271AEC, 32'hA93A072A,
      32'h1B3F6D9B, 32'h1E6321F5, 32'hF59C66FB, 32'h26DCF319, 32'h7533D928, 32'hB155FDF5,
      32'h03563482, 32'h8ABA3CBB, 32'h28517711, 32'hC20AD9F8, 32'hABCC5167, 32'hCCAD925F,
      32'h4DE81751, 32'h3830DC8E, 32'h379D5862, 32'h9320F991, 32'hEA7A90C2, 32'hFB3E7BCE,
      32'h5121CE64, 32'h774FBE32, 32'hA8B6E37E, 32'hC3293D46, 32'h48DE5369, 32'h6413E680,
      32'hA2AE0810, 32'hDD6DB224, 32'h69852DFD, 32'h09072166, 32'hB39A460A, 32'h6445C0DD,
      32'h586CDECF, 32'h1C20C8AE, 32'h5BBEF7DD, 32'h1B588D40, 32'hCCD2017F, 32'h6BB4E3BB,
      32'hDDA26A7E, 32'h3A59FF45, 32'h3E350A44, 32'hBCB4CDD5, 32'h72EACEA8, 32'hFA6484BB,
      32'h8D6612AE, 32'hBF3C6F47, 32'hD29BE463, 32'h542F5D9E, 32'hAEC2771B, 32'hF64E6370,
      32'h740E0D8D, 32'hE75B1357, 32'hF8721671, 32'hAF537D5D, 32'h4040CB08, 32'h4EB4E2CC,
      32'h34D2466A, 32'h0115AF84, 32'hE1B00428, 32'h95983A1D, 32'h06B89FB4, 32'hCE6EA048,
      32'h6F3F3B82, 32'h3520AB82, 32'h011A1D4B, 32'h277227F8, 32'h611560B1, 32'hE7933FDC,
      32'hBB3A792B, 32'h344525BD, 32'hA08839E1, 32'h51CE794B, 32'h2F32C9B7, 32'hA01FBAC9,
      32'hE01CC87E, 32'hBCC7D1F6, 32'hCF0111C3, 32'hA1E8AAC7, 32'h1A908749, 32'hD44FBD9A,
      32'hD0DADECB, 32'hD50ADA38, 32'h0339C32A, 32'hC6913667, 32'h8DF9317C, 32'hE0B12B4F,
      32'hF79E59B7, 32'h43F5BB3A, 32'hF2D519FF, 32'h27D9459C, 32'hBF97222C, 32'h15E6FC2A,
      32'h0F91FC71, 32'h9B941525, 32'hFAE59361, 32'hCEB69CEB, 32'hC2A86459, 32'h12BAA8D1,
      32'hB6C1075E, 32'hE3056A0C, 32'h10D25065, 32'hCB03A442, 32'hE0EC6E0E, 32'h1698DB3B,
      32'h4C98A0BE, 32'h3278E964, 32'h9F1F9532, 32'hE0D392DF, 32'hD3A0342B, 32'h8971F21E,
      32'h1B0A7441, 32'h4BA3348C, 32'hC5BE7120, 32'hC37632D8, 32'hDF359F8D, 32'h9B992F2E,
      32'hE60B6F47, 32'h0FE3F11D, 32'hE54CDA54, 32'h1EDAD891, 32'hCE6279CF, 32'hCD3E7E6F,
      32'h1618B166, 32'hFD2C1D05, 32'h848FD2C5, 32'hF6FB2299, 32'hF523F357, 32'hA6327623,
      32'h93A83531, 32'h56CCCD02, 32'hACF08162, 32'h5A75EBB5, 32'h6E163697, 32'h88D273CC,
      32'hDE966292, 32'h81B949D0, 32'h4C50901B, 32'h71C65614, 32'hE6C6C7BD, 32'h327A140A,
      32'h45E1D006, 32'hC3F27B9A, 32'hC9AA53FD, 32'h62A80F00, 32'hBB25BFE2, 32'h35BDD2F6,
      32'h71126905, 32'hB2040222, 32'hB6CBCF7C, 32'hCD769C2B, 32'h53113EC0, 32'h1640E3D3,
      32'h38ABBD60, 32'h2547ADF0, 32'hBA38209C, 32'hF746CE76, 32'h77AFA1C5, 32'h20756060,
      32'h85CBFE4E, 32'h8AE88DD8, 32'h7AAAF9B0, 32'h4CF9AA7E, 32'h1948C25C, 32'h02FB8A8C,
      32'h01C36AE4, 32'hD6EBE1F9, 32'h90D4F869, 32'hA65CDEA0, 32'h3F09252D, 32'hC208E69F,
      32'hB74E6132, 32'hCE77E25B, 32'h578FDFE3, 32'h3AC372E6
      }
   };

endpackage

@@ rtl/core/blowfish_block_cipher.sv @@
// Top level of the Blowfish engine: control, P-array, key store and S-box RAMs.
//
//  channel | dir | beat contents
//  req_    | in  | tuser func, tdata key_index/key_word/block_in, tlast last_block
//  rsp_    | out | tdata block_out, tlast last_block_out
//  csr_    | in  | key word count, written on csr_we
//
// Encrypt/decrypt: the accepting beat issues the first S-box reads, then one
// Feistel round per cycle runs through the S-box RAM read loop.
// Load: stores one key word. Expand: table restore, then 521 chained blocks,
// each with the write back of its result into the P-array or the S-boxes.
// After reset the same restore runs before the first beat is taken.
// A finished block waits in the output register while the next beat is taken;
// if that register is still full at the end, the core holds until it drains.
module blowfish_block_cipher
   import blf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,  // key_index[3:0], key_word[35:4], block_in[99:36], zero pad
   input  logic [1:0]   req_tuser,  // func[1:0]
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,  // block_out[63:0]
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [3:0]   csr_wdata
);

   state_type   state_ff, state_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic [31:0] l_ff, l_in, r_ff, r_in;
   logic        dec_ff, dec_in, last_ff, last_in, exp_ff, exp_in;
   logic [9:0]  pair_ff, pair_in;
   logic [3:0]  kidx_ff, kidx_in;
   logic [3:0]  kw_ff;
   logic [31:0] key_ff [MAX_KEY_WORDS];
   logic [31:0] key_in [MAX_KEY_WORDS];
   logic [31:0] p_ff [P_LEN];
   logic [31:0] p_in [P_LEN];
   logic        rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [63:0] rsp_data_ff, rsp_data_in;

   logic [3:0]  req_key_index;
   logic [31:0] req_key_word;
   logic [63:0] req_block;
   logic [3:0]  kw_eff;
   logic [4:0]  k_next, p_rd_idx;
   logic [31:0] p_rd, f_val, new_l, round_l, out_l, out_r, lx_in;
   logic [31:0] s_rd [SBOX_NUM];
   logic [9:0]  s_pair;
   logic [1:0]  s_box_sel;
   logic [7:0]  s_addr_lo;
   logic        last_round, rsp_free;
   sbox_wr_type s_wr [SBOX_NUM];

   assign req_key_index = req_tdata[3:0];
   assign req_key_word  = req_tdata[35:4];
   assign req_block     = req_tdata[99:36];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // effective key word count: zero acts as one, fifteen as fourteen
   always_comb begin
      kw_eff = kw_ff;
      if (kw_ff == 4'd0) begin
         kw_eff = 4'd1;
      end else if (kw_ff > 4'(MAX_KEY_WORDS)) begin
         kw_eff = 4'(MAX_KEY_WORDS);
      end
   end

   // P-array read index: first whitening word or next round's word
   assign k_next = {1'b0, cnt_ff[3:0]} + 5'd1;
   always_comb begin
      case (state_ff)
         ST_IDLE:  p_rd_idx = (req_tuser == FUNC_DECRYPT) ? 5'(P_LEN - 1) : 5'd0;
         ST_START: p_rd_idx = 5'd0;
         default:  p_rd_idx = dec_ff ? (5'(P_LEN - 1) - k_next) : k_next;
      endcase
   end
   assign p_rd = p_ff[p_rd_idx];

   // round datapath
   blf_feistel u_feistel (
      .s_word (s_rd),
      .f_out  (f_val)
   );

   assign new_l      = r_ff ^ f_val;
   assign round_l    = new_l ^ p_rd;
   assign out_r      = round_l;
   assign out_l      = l_ff ^ (dec_ff ? p_ff[0] : p_ff[P_LEN - 1]);
   assign last_round = (cnt_ff[3:0] == 4'(ROUNDS - 1));
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // whitened left half that addresses the S-boxes next cycle
   always_comb begin
      case (state_ff)
         ST_IDLE:  lx_in = req_block[63:32] ^ p_rd;
         ST_START: lx_in = l_ff ^ p_rd;
         default:  lx_in = round_l;
      endcase
   end

   // S-box write target during expansion
   assign s_pair    = pair_ff - 10'(P_PAIRS);
   assign s_box_sel = s_pair[8:7];
   assign s_addr_lo = {s_pair[6:0], 1'b0};

   for (genvar b = 0; b < SBOX_NUM; b++) begin : g_sbox
      always_comb begin
         s_wr[b] = '0;
         if (state_ff == ST_INIT) begin
            s_wr[b].we   = 1'b1;
            s_wr[b].addr = cnt_ff;
            s_wr[b].data = S_INIT[b][cnt_ff];
         end else if (state_ff == ST_ROUND && last_round && exp_ff &&
                      pair_ff >= 10'(P_PAIRS) && s_box_sel == 2'(b)) begin
            s_wr[b].we   = 1'b1;
            s_wr[b].addr = s_addr_lo;
            s_wr[b].data = out_l;
         end else if (state_ff == ST_WR2 && s_box_sel == 2'(b)) begin
            s_wr[b].we   = 1'b1;
            s_wr[b].addr = s_addr_lo | 8'd1;
            s_wr[b].data = r_ff;
         end
      end

      blf_sbox_ram u_ram (
         .clock   (clock),
         .wr      (s_wr[b]),
         .rd_addr (lx_in[31 - 8 * b -: 8]),
         .rd_data (s_rd[b])
      );
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      dec_in       = dec_ff;
      last_in      = last_ff;
      exp_in       = exp_ff;
      pair_in      = pair_ff;
      kidx_in      = kidx_ff;
      key_in       = key_ff;
      p_in         = p_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_tuser)
                  FUNC_LOAD: begin
                     if (req_key_index < 4'(MAX_KEY_WORDS)) begin
                        key_in[req_key_index] = req_key_word;
                     end
                  end
                  FUNC_EXPAND: begin
                     exp_in   = 1'b1;
                     cnt_in   = '0;
                     kidx_in  = '0;
                     state_in = ST_INIT;
                  end
                  default: begin
                     l_in     = lx_in;
                     r_in     = req_block[31:0];
                     dec_in   = (req_tuser == FUNC_DECRYPT);
                     last_in  = req_tlast;
                     cnt_in   = '0;
                     state_in = ST_ROUND;
                  end
               endcase
            end
         end
         ST_INIT: begin
            // restore tables; P entries also take the cycled key words
            if (cnt_ff < 8'(P_LEN)) begin
               p_in[cnt_ff[4:0]] = P_INIT[cnt_ff[4:0]] ^ key_ff[kidx_ff];
               kidx_in = (kidx_ff + 4'd1 == kw_eff) ? 4'd0 : kidx_ff + 4'd1;
            end
            cnt_in = cnt_ff + 8'd1;
            if (cnt_ff == 8'(SBOX_DEPTH - 1)) begin
               if (exp_ff) begin
                  l_in     = '0;
                  r_in     = '0;
                  dec_in   = 1'b0;
                  pair_in  = '0;
                  state_in = ST_START;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_START: begin
            l_in     = lx_in;
            cnt_in   = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (!last_round) begin
               l_in   = round_l;
               r_in   = l_ff;
               cnt_in = cnt_ff + 8'd1;
            end else if (exp_ff) begin
               l_in = out_l;
               r_in = out_r;
               if (pair_ff < 10'(P_PAIRS)) begin
                  p_in[{pair_ff[3:0], 1'b0}] = out_l;
                  p_in[{pair_ff[3:0], 1'b1}] = out_r;
                  pair_in  = pair_ff + 10'd1;
                  state_in = ST_START;
               end else begin
                  state_in = ST_WR2;
               end
            end else if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {out_l, out_r};
               rsp_last_in  = last_ff;
               state_in     = ST_IDLE;
            end else begin
               l_in     = out_l;
               r_in     = out_r;
               state_in = ST_HOLD;
            end
         end
         ST_WR2: begin
            if (pair_ff == 10'(P_PAIRS + S_PAIRS - 1)) begin
               exp_in   = 1'b0;
               state_in = ST_IDLE;
            end else begin
               pair_in  = pair_ff + 10'd1;
               state_in = ST_START;
            end
         end
         ST_HOLD: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {l_ff, r_ff};
               rsp_last_in  = last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         kidx_ff      <= '0;
         exp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         kw_ff        <= 4'(MAX_KEY_WORDS);
         for (int i = 0; i < MAX_KEY_WORDS; i++) begin
            key_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         kidx_ff      <= kidx_in;
         exp_ff       <= exp_in;
         rsp_valid_ff <= rsp_valid_in;
         key_ff       <= key_in;
         if (csr_we) begin
            kw_ff <= csr_wdata;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      l_ff        <= l_in;
      r_ff        <= r_in;
      dec_ff      <= dec_in;
      last_ff     <= last_in;
      pair_ff     <= pair_in;
      p_ff        <= p_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

@@ rtl/core/blf_sbox_ram.sv @@
// One 256 x 32 S-box RAM: one write port, one read port, registered read data.
module blf_sbox_ram
   import blf_pkg::*;
(
   input  logic        clock,
   input  sbox_wr_type wr,
   input  logic [7:0]  rd_addr,
   output logic [31:0] rd_data
);

   logic [31:0] mem [SBOX_DEPTH];
   logic [31:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/blf_feistel.sv @@
// Blowfish round function from the four S-box read words.
module blf_feistel
   import blf_pkg::*;
(
   input  logic [31:0] s_word [SBOX_NUM],
   output logic [31:0] f_out
);

   logic [31:0] sum01;

   // ((S0 + S1) ^ S2) + S3
   assign sum01 = s_word[0] + s_word[1];
   assign f_out = (sum01 ^ s_word[2]) + s_word[3];

endmodule

@@ verif/blowfish_block_cipher_test.sv @@
// Self-checking stimulus, cipher predictor and result scoreboard for the Blowfish engine.
module blowfish_block_cipher_test;
   import blf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int EXPAND_HOLD = 12000;   // cycles an expansion may still run after the last block
   localparam int STALL_LIMIT = 100000;  // cycles without any beat before giving up
   localparam int RAND_PHASES = 4;
   localparam int PHASE_ITEMS = 300;

   typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [1:0]   func;
      logic [3:0]   key_index;
      logic [31:0]  key_word;
      logic [63:0]  block;
      logic         last;
      bit           known;      // expected block typed in below
      logic [63:0]  known_block;
   } stim_row_type;

   typedef struct {
      logic [63:0] block;
      logic        last;
   } cipher_out_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;  // key_index[3:0], key_word[35:4], block_in[99:36], zero pad
   logic [1:0]   req_tuser = FUNC_LOAD;  // func[1:0]
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;  // block_out[63:0]
   logic         rsp_tlast;
   logic         csr_we = 1'b0;
   logic [3:0]   csr_wdata = '0;

   // predictor copy of the engine state
   logic [31:0] pbox_model [P_LEN];
   logic [31:0] sbox_model [SBOX_NUM*SBOX_DEPTH];
   logic [31:0] key_model  [MAX_KEY_WORDS];
   logic [3:0]  key_count_model;

   cipher_out_type block_queue [$];
   stim_row_type   stim_rows [$];
   int mismatches = 0;
   int blocks_seen = 0;
   int expands_sent = 0;
   int idle_cycles = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;

   blowfish_block_cipher DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // pi-derived starting tables
   function automatic void restore_tables();
      for (int i = 0; i < P_LEN; i++) pbox_model[i] = P_INIT[i];
      for (int b = 0; b < SBOX_NUM; b++)
         for (int j = 0; j < SBOX_DEPTH; j++) sbox_model[b*SBOX_DEPTH+j] = S_INIT[b][j];
   endfunction

   function automatic logic [31:0] feistel(logic [31:0] x);
      logic [31:0] v;
      v = sbox_model[x[31:24]] + sbox_model[256 + x[23:16]];
      v = v ^ sbox_model[512 + x[15:8]];
      return v + sbox_model[768 + x[7:0]];
   endfunction

   function automatic logic [63:0] cipher_block(logic [63:0] blk, bit dec);
      logic [31:0] l, r, t;
      l = blk[63:32];
      r = blk[31:0];
      for (int i = 0; i < ROUNDS; i++) begin
         l = l ^ (dec ? pbox_model[ROUNDS+1-i] : pbox_model[i]);
         r = r ^ feistel(l);
         t = l; l = r; r = t;
      end
      t = l; l = r; r = t;
      if (dec) begin
         r = r ^ pbox_model[1];
         l = l ^ pbox_model[0];
      end else begin
         r = r ^ pbox_model[ROUNDS];
         l = l ^ pbox_model[ROUNDS+1];
      end
      return {l, r};
   endfunction

   function automatic void expand_schedule();
      int n;
      logic [63:0] blk;
      n = key_count_model;
      if (n == 0) n = 1;
      if (n > MAX_KEY_WORDS) n = MAX_KEY_WORDS;
      restore_tables();
      for (int i = 0; i < P_LEN; i++) pbox_model[i] = pbox_model[i] ^ key_model[i % n];
      blk = '0;
      for (int i = 0; i < P_LEN; i += 2) begin
         blk = cipher_block(blk, 1'b0);
         pbox_model[i] = blk[63:32];
         pbox_model[i+1] = blk[31:0];
      end
      for (int i = 0; i < SBOX_NUM*SBOX_DEPTH; i += 2) begin
         blk = cipher_block(blk, 1'b0);
         sbox_model[i] = blk[63:32];
         sbox_model[i+1] = blk[31:0];
      end
   endfunction

   // update the model for one accepted beat and queue the block an encrypt or decrypt beat yields
   function automatic void predict_beat(stim_row_type row);
      cipher_out_type res;
      case (row.func)
         FUNC_LOAD: begin
            if (row.key_index < MAX_KEY_WORDS) key_model[row.key_index] = row.key_word;
         end
         FUNC_EXPAND: begin
            expand_schedule();
            expands_sent++;
         end
         default: begin
            res.block = cipher_block(row.block, row.func == FUNC_DECRYPT);
            if (row.known) res.block = row.known_block;
            res.last = row.last;
            block_queue.push_back(res);
         end
      endcase
   endfunction

   task automatic send_beat(stim_row_type row);
      while ($urandom_range(99) < sender_idle_pct) @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = row.func;
      req_tdata  = {4'b0, row.block, row.key_word, row.key_index};
      req_tlast  = row.last;
      do @(posedge clock); while (!req_tready);
      predict_beat(row);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // drain, let a possible expansion finish, then write the key word count
   task automatic write_key_count(logic [3:0] value);
      while (block_queue.size() != 0) @(negedge clock);
      repeat (EXPAND_HOLD) @(negedge clock);
      csr_we = 1'b1;
      csr_wdata = value;
      key_count_model = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic void add_row(row_kind_type kind, logic [1:0] func, logic [3:0] ki,
                                   logic [31:0] kw, logic [63:0] blk, logic lb,
                                   bit known, logic [63:0] kb);
      stim_row_type row;
      row.kind = kind; row.func = func; row.key_index = ki; row.key_word = kw;
      row.block = blk; row.last = lb; row.known = known; row.known_block = kb;
      stim_rows.push_back(row);
   endfunction

   function automatic stim_row_type random_row();
      stim_row_type row;
      int pick;
      pick = $urandom_range(999);
      row.kind = ROW_BEAT;
      row.key_index = $urandom_range(15);
      row.key_word = $urandom;
      row.block = {$urandom, $urandom};
      row.last = $urandom_range(1);
      row.known = 0;
      row.known_block = '0;
      if (pick < 12) row.func = FUNC_EXPAND;
      else if (pick < 180) row.func = FUNC_LOAD;
      else if (pick < 590) row.func = FUNC_ENCRYPT;
      else row.func = FUNC_DECRYPT;
      return row;
   endfunction

   // receiver backpressure
   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);

   // result scoreboard and watchdog
   always @(posedge clock) begin
      cipher_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         blocks_seen++;
         if (block_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected block %h last %b", rsp_tdata, rsp_tlast);
         end else begin
            want = block_queue.pop_front();
            if (rsp_tdata !== want.block || rsp_tlast !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("block mismatch: expected %h last %b, got %h last %b",
                           want.block, want.last, rsp_tdata, rsp_tlast);
            end
         end
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("[blowfish_block_cipher] ERROR");
         $finish;
      end
   end

   initial begin
      stim_row_type row;
      restore_tables();
      foreach (key_model[i]) key_model[i] = '0;
      key_count_model = MAX_KEY_WORDS;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // directed rows: pi tables, all-zero and all-one key vectors, count extremes
      add_row(ROW_BEAT, FUNC_ENCRYPT, 4'hF, 32'hFFFFFFFF, 64'h0, 1'b0, 0, 0);
      add_row(ROW_BEAT, FUNC_DECRYPT, 4'h0, 32'h0, 64'hFFFFFFFFFFFFFFFF, 1'b1, 0, 0);
      add_row(ROW_BEAT, FUNC_EXPAND, 4'hF, 32'hFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 1'b1, 0, 0);
      add_row(ROW_BEAT, FUNC_ENCRYPT, 4'h0, 32'h0, 64'h0, 1'b1, 1, 64'h4EF997456198DD78);
      add_row(ROW_BEAT, FUNC_DECRYPT, 4'h0, 32'h0, 64'h4EF997456198DD78, 1'b0, 1, 64'h0);
      add_row(ROW_BEAT, FUNC_LOAD, 4'd14, 32'h12345678, 64'hFFFFFFFFFFFFFFFF, 1'b1, 0, 0);
      add_row(ROW_BEAT, FUNC_LOAD, 4'd15, 32'hFFFFFFFF, 64'h0, 1'b0, 0, 0);
      add_row(ROW_CFG, FUNC_LOAD, 4'd2, 0, 0, 0, 0, 0);
      add_row(ROW_BEAT, FUNC_LOAD, 4'd0, 32'hFFFFFFFF, 64'h0, 1'b1, 0, 0);
      add_row(ROW_BEAT, FUNC_LOAD, 4'd1, 32'hFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 1'b0, 0, 0);
      add_row(ROW_BEAT, FUNC_EXPAND, 4'd0, 32'h0, 64'h0, 1'b0, 0, 0);
      add_row(ROW_BEAT, FUNC_ENCRYPT, 4'd0, 32'h0, 64'hFFFFFFFFFFFFFFFF, 1'b0, 1,
              64'h51866FD5B85ECB8A);
      add_row(ROW_BEAT, FUNC_DECRYPT, 4'hF, 32'hFFFFFFFF, 64'h51866FD5B85ECB8A, 1'b1, 1,
              64'hFFFFFFFFFFFFFFFF);
      add_row(ROW_BEAT, FUNC_LOAD, 4'd13, 32'hA5A5A5A5, 64'h0, 1'b0, 0, 0);
      add_row(ROW_CFG, FUNC_LOAD, 4'd0, 0, 0, 0, 0, 0);  // zero count acts as one
      add_row(ROW_BEAT, FUNC_EXPAND, 4'd0, 32'h0, 64'h0, 1'b0, 0, 0);
      add_row(ROW_BEAT, FUNC_ENCRYPT, 4'd0, 32'h0, 64'h0123456789ABCDEF, 1'b1, 0, 0);
      add_row(ROW_CFG, FUNC_LOAD, 4'd15, 0, 0, 0, 0, 0);  // oversized count clamps
      add_row(ROW_BEAT, FUNC_EXPAND, 4'd0, 32'h0, 64'h0, 1'b0, 0, 0);
      add_row(ROW_BEAT, FUNC_DECRYPT, 4'd0, 32'h0, 64'hFEDCBA9876543210, 1'b0, 0, 0);
      add_row(ROW_CFG, FUNC_LOAD, 4'd1, 0, 0, 0, 0, 0);
      add_row(ROW_BEAT, FUNC_EXPAND, 4'd0, 32'h0, 64'h0, 1'b0, 0, 0);
      add_row(ROW_BEAT, FUNC_ENCRYPT, 4'd0, 32'h0, 64'h8000000000000001, 1'b1, 0, 0);

      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_CFG) write_key_count(stim_rows[i].key_index);
         else send_beat(stim_rows[i]);
      end

      // random phases, each under a new key word count and four idling mixes
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         case (ph)
            0: write_key_count(4'd14);
            1: write_key_count(4'($urandom_range(15)));
            2: write_key_count(4'd1);
            default: write_key_count(4'($urandom_range(2, 13)));
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            case ((n * 4) / PHASE_ITEMS)
               0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
               1: begin sender_idle_pct = 62; receiver_stall_pct = 0;  end
               2: begin sender_idle_pct = 0;  receiver_stall_pct = 62; end
               default: begin sender_idle_pct = 9; receiver_stall_pct = 9; end
            endcase
            row = random_row();
            send_beat(row);
            // now and then decrypt the block just produced, a full round trip
            if (row.func == FUNC_ENCRYPT && $urandom_range(7) == 0) begin
               row.func = FUNC_DECRYPT;
               row.block = block_queue[$].block;
               send_beat(row);
            end
         end
      end

      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      while (block_queue.size() != 0) @(negedge clock);
      repeat (EXPAND_HOLD) @(negedge clock);

      $display("covered %0d result blocks and %0d key expansions over five key word counts",
               blocks_seen, expands_sent);
      $display("idling mixes: none, sender gaps, receiver stalls, both; mismatches %0d",
               mismatches);
      if (mismatches == 0 && block_queue.size() == 0) begin
         $display("[blowfish_block_cipher] OK");
      end else begin
         $display("[blowfish_block_cipher] ERROR");
      end
      $finish;
   end

endmodule
